@@ rtl/core/cgs_pkg.sv @@
// ============================================================================
// cgs_pkg
// Shared types, codes and saturating fixed-point helpers for the
// conjugate-gradient solver core.
// ============================================================================
`default_nettype none

package cgs_pkg;

   // Default build values
   localparam int SYSTEM_SIZE_DEF   = 16;
   localparam int FRACTION_BITS_DEF = 16;

   // Register reset values
   localparam logic [15:0] MAX_ITER_RESET  = 16'd100;
   localparam logic [30:0] TOLERANCE_RESET = 31'd66;

   // Input transaction opcodes
   localparam logic [1:0] OP_LOAD_MATRIX = 2'd0;
   localparam logic [1:0] OP_LOAD_RHS    = 2'd1;
   localparam logic [1:0] OP_LOAD_X      = 2'd2;
   localparam logic [1:0] OP_START       = 2'd3;

   // Register indexes
   localparam logic CSR_MAX_ITERATIONS = 1'b0;
   localparam logic CSR_TOLERANCE      = 1'b1;

   // One element of every vector, held in one cell
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] b;
      logic signed [31:0] r;
      logic signed [31:0] d;
      logic signed [31:0] p;
   } cgs_vec_type;

   // Per-field shift enables along the chain
   typedef struct packed {
      logic x;
      logic b;
      logic r;
      logic d;
      logic p;
   } cgs_shift_type;

   // Clamp a wide value into 32-bit signed range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] res;
      if (v > 64'sd2147483647) begin
         res = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         res = 32'sh80000000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

   // Saturating 64-bit signed add
   function automatic logic signed [63:0] add64s(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic [64:0] s;
      logic signed [63:0] res;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         res = s[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
      end else begin
         res = s[63:0];
      end
      return res;
   endfunction

   // Saturating 32-bit signed add
   function automatic logic signed [31:0] add32s(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [63:0] s;
      s = 64'(a) + 64'(b);
      return sat32(s);
   endfunction

   // Saturating 32-bit signed subtract
   function automatic logic signed [31:0] sub32s(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [63:0] s;
      s = 64'(a) - 64'(b);
      return sat32(s);
   endfunction

   // Drop fraction bits of a wide product with floor rounding, then clamp
   function automatic logic signed [31:0] scale_down(input logic signed [63:0] v,
                                                     input int unsigned fbits);
      logic signed [63:0] s;
      s = v >>> fbits;
      return sat32(s);
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/cgs_cell.sv @@
// ============================================================================
// cgs_cell
// One link of the vector chain: holds element i of x, b, r, d and p and
// takes its neighbor's fields when the matching shift enable is set.
// ============================================================================
`default_nettype none

module cgs_cell (
   input  wire logic                   clock,
   input  wire cgs_pkg::cgs_shift_type shift,
   input  wire cgs_pkg::cgs_vec_type   nbr,
   input  wire logic                   ld_x,
   input  wire logic                   ld_b,
   input  wire logic signed [31:0]     ld_value,
   output cgs_pkg::cgs_vec_type        q
);

   cgs_pkg::cgs_vec_type vec_ff;
   cgs_pkg::cgs_vec_type vec_in;

   // Shift from neighbor or load from the host
   always_comb begin
      vec_in = vec_ff;
      if (shift.x) begin
         vec_in.x = nbr.x;
      end else if (ld_x) begin
         vec_in.x = ld_value;
      end
      if (shift.b) begin
         vec_in.b = nbr.b;
      end else if (ld_b) begin
         vec_in.b = ld_value;
      end
      if (shift.r) begin
         vec_in.r = nbr.r;
      end
      if (shift.d) begin
         vec_in.d = nbr.d;
      end
      if (shift.p) begin
         vec_in.p = nbr.p;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end

   assign q = vec_ff;

endmodule

`default_nettype wire

@@ rtl/core/cgs_matrix_mem.sv @@
// ============================================================================
// cgs_matrix_mem
// Matrix storage: one write port, one read port with registered data.
// ============================================================================
`default_nettype none

module cgs_matrix_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire logic signed [31:0]  wr_data,
   input  wire logic [AW-1:0]       rd_addr,
   output logic signed [31:0]       rd_data
);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_data_ff;

   // Write the host element
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read every cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/cgs_divider.sv @@
// ============================================================================
// cgs_divider
// Bit-serial restoring divider: num * 2^F / den, truncated toward zero and
// clamped to 32 bits; a zero divisor gives zero.
// ============================================================================
`default_nettype none

module cgs_divider #(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] num,
   input  wire logic signed [63:0] den,
   output logic                    done,
   output logic signed [31:0]      quotient
);

   localparam int DW = 64 + FRACTION_BITS;
   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          fin_ff, fin_in;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic          neg_ff;
   logic          zero_ff;
   logic          ovf_ff;
   logic [63:0]   den_ff;
   logic [DW-1:0] sh_ff;
   logic [63:0]   rem_ff;
   logic [32:0]   q_ff;
   logic signed [31:0] res_ff;

   logic [63:0]   num_mag;
   logic [63:0]   den_mag;
   logic [64:0]   rem_sh;
   logic [64:0]   rem_diff;
   logic          ge;
   logic [63:0]   rem_nx;
   logic [32:0]   limit;
   logic          sat;
   logic signed [31:0] res;
   logic          last_bit;

   // Magnitudes and one restoring step
   always_comb begin
      num_mag  = num[63] ? (64'd0 - num) : num;
      den_mag  = den[63] ? (64'd0 - den) : den;
      rem_sh   = {rem_ff, sh_ff[DW-1]};
      rem_diff = rem_sh - {1'b0, den_ff};
      ge       = (rem_sh >= {1'b0, den_ff});
      rem_nx   = ge ? rem_diff[63:0] : rem_sh[63:0];
      limit    = neg_ff ? 33'h080000000 : 33'h07FFFFFFF;
      sat      = ovf_ff || (q_ff > limit);
      if (zero_ff) begin
         res = '0;
      end else if (sat) begin
         res = neg_ff ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else if (neg_ff) begin
         res = 32'sd0 - $signed(q_ff[31:0]);
      end else begin
         res = $signed(q_ff[31:0]);
      end
      last_bit = (cnt_ff == CW'(1));
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      if (start) begin
         busy_in = (den != 64'sd0);
         fin_in  = (den == 64'sd0);
      end else if (busy_ff && last_bit) begin
         busy_in = 1'b0;
         fin_in  = 1'b1;
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= fin_ff;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= num[63] ^ den[63];
         zero_ff <= (den == 64'sd0);
         den_ff  <= den_mag;
         sh_ff   <= {num_mag, {FRACTION_BITS{1'b0}}};
         rem_ff  <= '0;
         q_ff    <= '0;
         ovf_ff  <= 1'b0;
         cnt_ff  <= CW'(DW);
      end else if (busy_ff) begin
         sh_ff  <= {sh_ff[DW-2:0], 1'b0};
         rem_ff <= rem_nx;
         q_ff   <= {q_ff[31:0], ge};
         ovf_ff <= ovf_ff | q_ff[32];
         cnt_ff <= cnt_ff - CW'(1);
      end
      if (fin_ff) begin
         res_ff <= res;
      end
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

`default_nettype wire

@@ rtl/core/conjugate_gradient_solver_core.sv @@
// ============================================================================
// conjugate_gradient_solver_core
// Fixed-point conjugate-gradient solver with a chain of vector cells, one
// shared multiplier and a bit-serial divider.
// ============================================================================
// Load transactions (A, b, x elements) are accepted while the core is idle. A
// start transaction runs whole passes over the stored system; each element
// step goes through the one shared multiplier in load, multiply and
// accumulate phases, and a matrix row adds a phase that writes the row sum.
// The first pass holds two matrix-vector products and the vector sweeps,
// each later pass one product and its sweeps, plus up to N+2 bit-serial
// divisions (beta in later passes, step length and one relative change per
// nonzero x element). The vector chain rotates its elements past the head,
// where the multiplier, adders and divider sit. After the last pass the N
// solution elements leave one per accepted response; no request is taken
// until then.
// ============================================================================
`default_nettype none

module conjugate_gradient_solver_core #(
   parameter int SYSTEM_SIZE   = cgs_pkg::SYSTEM_SIZE_DEF,
   parameter int FRACTION_BITS = cgs_pkg::FRACTION_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [3:0]         req_row_index,
   input  wire logic [3:0]         req_col_index,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [3:0]              rsp_element_index,
   output logic signed [31:0]      rsp_solution_value,
   output logic                    rsp_converged,
   output logic [16:0]             rsp_iterations_used,
   output logic                    rsp_last,
   input  wire logic               csr_write_enable,
   input  wire logic               csr_index,
   input  wire logic [30:0]        csr_write_data
);

   localparam int IDX_W = $clog2(SYSTEM_SIZE);
   localparam int DEPTH = SYSTEM_SIZE * SYSTEM_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SYSTEM_SIZE - 1);

   // Element step phases
   localparam logic [1:0] PH_LOAD = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_ACT  = 2'd2;
   localparam logic [1:0] PH_WAIT = 2'd3;

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_MVX   = 13'b0000000000010,
      ST_RES0  = 13'b0000000000100,
      ST_RUPD  = 13'b0000000001000,
      ST_RR    = 13'b0000000010000,
      ST_BETA  = 13'b0000000100000,
      ST_DUPD  = 13'b0000001000000,
      ST_MVD   = 13'b0000010000000,
      ST_DAD   = 13'b0000100000000,
      ST_STEP  = 13'b0001000000000,
      ST_XUPD  = 13'b0010000000000,
      ST_CHECK = 13'b0100000000000,
      ST_EMIT  = 13'b1000000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         ph_ff, ph_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [16:0]        k_ff, k_in;
   logic [15:0]        max_it_ff, max_it_in;
   logic [30:0]        tol_ff, tol_in;
   logic               conv_ff, conv_in;
   logic               zero_seen_ff, zero_seen_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] rr_ff, rr_in;
   logic signed [63:0] dad_ff, dad_in;
   logic signed [63:0] old_ff, old_in;
   logic signed [31:0] step_ff, step_in;
   logic signed [31:0] beta_ff, beta_in;
   logic signed [31:0] maxrel_ff, maxrel_in;
   logic signed [31:0] xn_ff, xn_in;
   logic signed [31:0] opa_ff, opa_in;
   logic signed [31:0] opb_ff, opb_in;
   logic signed [63:0] prod_ff, prod_in;

   cgs_pkg::cgs_vec_type   cell_q [SYSTEM_SIZE];
   cgs_pkg::cgs_vec_type   head;
   cgs_pkg::cgs_vec_type   tail;
   cgs_pkg::cgs_shift_type shift;
   logic [SYSTEM_SIZE-1:0] cell_ld_x;
   logic [SYSTEM_SIZE-1:0] cell_ld_b;

   logic               req_go;
   logic               row_ok;
   logic               col_ok;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [AW-1:0]      mem_raddr;
   logic signed [31:0] mem_rd;

   logic               div_start;
   logic               div_go;
   logic               xdiv_armed_ff, xdiv_armed_in;
   logic               xdiv_go;
   logic signed [63:0] div_num;
   logic signed [63:0] div_den;
   logic               div_done;
   logic signed [31:0] div_q;

   logic signed [31:0] mul_a;
   logic signed [63:0] mul_full;
   logic signed [63:0] acc_sum;
   logic signed [31:0] mulq_v;
   logic signed [31:0] xn_v;
   logic signed [31:0] res_v;
   logic               last_i;
   logic               last_j;
   logic               elem_adv;
   state_type          sweep_next;
   logic [16:0]        k_next;

   assign head = cell_q[0];

   // Host load decode
   assign req_go    = req_valid && req_ready;
   assign row_ok    = (int'(req_row_index) < SYSTEM_SIZE);
   assign col_ok    = (int'(req_col_index) < SYSTEM_SIZE);
   assign mem_we    = req_go && (req_opcode == cgs_pkg::OP_LOAD_MATRIX) && row_ok && col_ok;
   assign mem_waddr = AW'(int'(req_row_index) * SYSTEM_SIZE + int'(req_col_index));
   assign mem_raddr = AW'(int'(i_ff) * SYSTEM_SIZE + int'(j_ff));

   cgs_matrix_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (req_value),
      .rd_addr (mem_raddr),
      .rd_data (mem_rd)
   );

   // Vector chain: cell i takes from cell i+1, the last cell from the tail
   for (genvar g = 0; g < SYSTEM_SIZE; g++) begin : g_cell
      assign cell_ld_x[g] = req_go && (req_opcode == cgs_pkg::OP_LOAD_X) && row_ok
                            && (int'(req_row_index) == g);
      assign cell_ld_b[g] = req_go && (req_opcode == cgs_pkg::OP_LOAD_RHS) && row_ok
                            && (int'(req_row_index) == g);
      if (g == SYSTEM_SIZE - 1) begin : g_tail
         cgs_cell u_cell (
            .clock    (clock),
            .shift    (shift),
            .nbr      (tail),
            .ld_x     (cell_ld_x[g]),
            .ld_b     (cell_ld_b[g]),
            .ld_value (req_value),
            .q        (cell_q[g])
         );
      end else begin : g_body
         cgs_cell u_cell (
            .clock    (clock),
            .shift    (shift),
            .nbr      (cell_q[g+1]),
            .ld_x     (cell_ld_x[g]),
            .ld_b     (cell_ld_b[g]),
            .ld_value (req_value),
            .q        (cell_q[g])
         );
      end
   end

   cgs_divider #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // Shared arithmetic at the head of the chain
   always_comb begin
      mul_a    = (state_ff == ST_MVX || state_ff == ST_MVD) ? mem_rd : opa_ff;
      mul_full = mul_a * opb_ff;
      acc_sum  = cgs_pkg::add64s(acc_ff, prod_ff);
      mulq_v   = cgs_pkg::scale_down(prod_ff, FRACTION_BITS);
      xn_v     = cgs_pkg::add32s(head.x, mulq_v);
      res_v    = cgs_pkg::sub32s(head.b, head.p);
      last_i   = (i_ff == LAST_IDX);
      last_j   = (j_ff == LAST_IDX);
      k_next   = k_ff + 17'd1;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      conv_in      = conv_ff;
      zero_seen_in = zero_seen_ff;
      acc_in       = acc_ff;
      rr_in        = rr_ff;
      dad_in       = dad_ff;
      old_in       = old_ff;
      step_in      = step_ff;
      beta_in      = beta_ff;
      maxrel_in    = maxrel_ff;
      xn_in        = xn_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      prod_in      = (ph_ff == PH_MUL) ? mul_full : prod_ff;
      shift        = '0;
      tail         = head;
      div_start    = 1'b0;
      div_num      = rr_ff;
      div_den      = dad_ff;
      elem_adv     = 1'b0;
      sweep_next   = state_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_go && req_opcode == cgs_pkg::OP_START) begin
               k_in     = '0;
               i_in     = '0;
               j_in     = '0;
               ph_in    = PH_LOAD;
               acc_in   = '0;
               state_in = ST_MVX;
            end
         end

         // Matrix-vector product into the p chain, one row at a time
         ST_MVX, ST_MVD: begin
            case (ph_ff)
               PH_LOAD: begin
                  opb_in = (state_ff == ST_MVX) ? head.x : head.d;
                  ph_in  = PH_MUL;
               end
               PH_MUL: begin
                  ph_in = PH_ACT;
               end
               PH_ACT: begin
                  acc_in = acc_sum;
                  if (state_ff == ST_MVX) begin
                     shift.x = 1'b1;
                  end else begin
                     shift.d = 1'b1;
                  end
                  if (last_j) begin
                     ph_in = PH_WAIT;
                  end else begin
                     j_in  = j_ff + IDX_W'(1);
                     ph_in = PH_LOAD;
                  end
               end
               default: begin
                  shift.p = 1'b1;
                  tail.p  = cgs_pkg::scale_down(acc_ff, FRACTION_BITS);
                  acc_in  = '0;
                  j_in    = '0;
                  ph_in   = PH_LOAD;
                  if (last_i) begin
                     i_in     = '0;
                     state_in = (state_ff == ST_MVX) ? ST_RES0 : ST_DAD;
                  end else begin
                     i_in = i_ff + IDX_W'(1);
                  end
               end
            endcase
         end

         // Elementwise sweeps and dot products
         ST_RES0, ST_RUPD, ST_RR, ST_DUPD, ST_DAD: begin
            case (ph_ff)
               PH_LOAD: begin
                  opa_in = head.r;
                  opb_in = head.r;
                  if (state_ff == ST_RUPD) begin
                     opa_in = step_ff;
                     opb_in = head.p;
                  end else if (state_ff == ST_DUPD) begin
                     opa_in = beta_ff;
                     opb_in = head.d;
                  end else if (state_ff == ST_DAD) begin
                     opa_in = head.d;
                     opb_in = head.p;
                  end
                  ph_in = PH_MUL;
               end
               PH_MUL: begin
                  ph_in = PH_ACT;
               end
               default: begin
                  elem_adv = 1'b1;
                  if (state_ff == ST_RES0) begin
                     shift.b    = 1'b1;
                     shift.p    = 1'b1;
                     shift.r    = 1'b1;
                     shift.d    = 1'b1;
                     tail.r     = res_v;
                     tail.d     = res_v;
                     sweep_next = ST_RR;
                  end else if (state_ff == ST_RUPD) begin
                     shift.r    = 1'b1;
                     shift.p    = 1'b1;
                     tail.r     = cgs_pkg::sub32s(head.r, mulq_v);
                     sweep_next = ST_RR;
                  end else if (state_ff == ST_RR) begin
                     shift.r    = 1'b1;
                     acc_in     = acc_sum;
                     sweep_next = (k_ff == 17'd0) ? ST_MVD : ST_BETA;
                     if (last_i) begin
                        rr_in  = acc_sum;
                        acc_in = '0;
                     end
                  end else if (state_ff == ST_DUPD) begin
                     shift.r    = 1'b1;
                     shift.d    = 1'b1;
                     tail.d     = cgs_pkg::add32s(head.r, mulq_v);
                     sweep_next = ST_MVD;
                  end else begin
                     shift.d    = 1'b1;
                     shift.p    = 1'b1;
                     acc_in     = acc_sum;
                     sweep_next = ST_STEP;
                     if (last_i) begin
                        dad_in = acc_sum;
                        acc_in = '0;
                     end
                  end
               end
            endcase
         end

         // Beta and step length through the divider
         ST_BETA, ST_STEP: begin
            div_num = rr_ff;
            div_den = (state_ff == ST_BETA) ? old_ff : dad_ff;
            if (ph_ff == PH_LOAD) begin
               div_start = 1'b1;
               ph_in     = PH_WAIT;
            end else if (div_done) begin
               ph_in = PH_LOAD;
               if (state_ff == ST_BETA) begin
                  beta_in  = div_q;
                  state_in = ST_DUPD;
               end else begin
                  step_in      = div_q;
                  old_in       = rr_ff;
                  maxrel_in    = '0;
                  zero_seen_in = 1'b0;
                  state_in     = ST_XUPD;
               end
            end
         end

         // Update x and track the largest relative change
         ST_XUPD: begin
            div_num = 64'(xn_ff) - 64'(head.x);
            div_den = 64'(head.x);
            case (ph_ff)
               PH_LOAD: begin
                  opa_in = step_ff;
                  opb_in = head.d;
                  ph_in  = PH_MUL;
               end
               PH_MUL: begin
                  ph_in = PH_ACT;
               end
               PH_ACT: begin
                  xn_in = xn_v;
                  if (head.x == 32'sd0) begin
                     zero_seen_in = 1'b1;
                     shift.x      = 1'b1;
                     shift.d      = 1'b1;
                     tail.x       = xn_v;
                     elem_adv     = 1'b1;
                     sweep_next   = ST_CHECK;
                  end else begin
                     ph_in = PH_WAIT;
                  end
               end
               default: begin
                  if (div_done) begin
                     if (div_q > maxrel_ff) begin
                        maxrel_in = div_q;
                     end
                     shift.x    = 1'b1;
                     shift.d    = 1'b1;
                     tail.x     = xn_ff;
                     elem_adv   = 1'b1;
                     sweep_next = ST_CHECK;
                  end
               end
            endcase
         end

         // Count the pass and decide whether to stop
         ST_CHECK: begin
            k_in  = k_next;
            i_in  = '0;
            ph_in = PH_LOAD;
            if (!zero_seen_ff && (maxrel_ff < $signed({1'b0, tol_ff}))) begin
               conv_in  = 1'b1;
               state_in = ST_EMIT;
            end else if (k_next > {1'b0, max_it_ff}) begin
               conv_in  = 1'b0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_RUPD;
            end
         end

         // Hand out x, one element per accepted transaction
         ST_EMIT: begin
            if (rsp_ready) begin
               shift.x = 1'b1;
               if (last_i) begin
                  i_in     = '0;
                  state_in = ST_IDLE;
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Advance to the next element of a sweep
      if (elem_adv) begin
         ph_in = PH_LOAD;
         if (last_i) begin
            i_in     = '0;
            state_in = sweep_next;
         end else begin
            i_in = i_ff + IDX_W'(1);
         end
      end
   end

   // Relative-change division launch: first cycle of the wait phase
   always_comb begin
      xdiv_armed_in = xdiv_armed_ff;
      if (state_ff == ST_XUPD && ph_ff == PH_ACT && head.x != 32'sd0) begin
         xdiv_armed_in = 1'b1;
      end else if (xdiv_armed_ff) begin
         xdiv_armed_in = 1'b0;
      end
      xdiv_go = xdiv_armed_ff;
   end

   // Configuration registers
   always_comb begin
      max_it_in = max_it_ff;
      tol_in    = tol_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            cgs_pkg::CSR_MAX_ITERATIONS: max_it_in = csr_write_data[15:0];
            cgs_pkg::CSR_TOLERANCE:      tol_in    = csr_write_data;
            default:                     tol_in    = tol_ff;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ph_ff         <= PH_LOAD;
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         conv_ff       <= 1'b0;
         xdiv_armed_ff <= 1'b0;
         max_it_ff     <= cgs_pkg::MAX_ITER_RESET;
         tol_ff        <= cgs_pkg::TOLERANCE_RESET;
      end else begin
         state_ff      <= state_in;
         ph_ff         <= ph_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         k_ff          <= k_in;
         conv_ff       <= conv_in;
         xdiv_armed_ff <= xdiv_armed_in;
         max_it_ff     <= max_it_in;
         tol_ff        <= tol_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      zero_seen_ff <= zero_seen_in;
      acc_ff       <= acc_in;
      rr_ff        <= rr_in;
      dad_ff       <= dad_in;
      old_ff       <= old_in;
      step_ff      <= step_in;
      beta_ff      <= beta_in;
      maxrel_ff    <= maxrel_in;
      xn_ff        <= xn_in;
      opa_ff       <= opa_in;
      opb_ff       <= opb_in;
      prod_ff      <= prod_in;
   end

   // Divider launch: sequencer starts for beta and step, the armed flag for x
   assign div_go = div_start || xdiv_go;

   // Port outputs
   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = (state_ff == ST_EMIT);
   assign rsp_element_index   = 4'(i_ff);
   assign rsp_solution_value  = head.x;
   assign rsp_converged       = conv_ff;
   assign rsp_iterations_used = k_ff;
   assign rsp_last            = last_i;

   // Requests and responses never open together
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response channels open at once");

   // The final response returns the block to accepting requests
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("block not idle after last response");

   // A start transaction closes the request channel
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode == cgs_pkg::OP_START) |=> !req_ready)
      else $error("request channel open after start");

endmodule

`default_nettype wire
